### hdl/http_request_head_parser_macros.svh
// Assertion macros shared by the HTTP request head parser.
`ifndef HTTP_REQUEST_HEAD_PARSER_MACROS_SVH
`define HTTP_REQUEST_HEAD_PARSER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define HRHP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("parser assertion failed");

// Next-cycle implication, checked out of reset.
`define HRHP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("parser assertion failed");

`endif

### hdl/hrhp_pkg.sv
// Types, codes and constants of the HTTP request head parser.
package hrhp_pkg;

  localparam int VERSION_BITS_DEF = 8;
  localparam int STATE_W = 5;

  localparam logic [STATE_W-1:0] PS_METHOD_START = 5'd0;
  localparam logic [STATE_W-1:0] PS_METHOD       = 5'd1;
  localparam logic [STATE_W-1:0] PS_URI          = 5'd2;
  localparam logic [STATE_W-1:0] PS_H            = 5'd3;
  localparam logic [STATE_W-1:0] PS_T1           = 5'd4;
  localparam logic [STATE_W-1:0] PS_T2           = 5'd5;
  localparam logic [STATE_W-1:0] PS_P            = 5'd6;
  localparam logic [STATE_W-1:0] PS_SLASH        = 5'd7;
  localparam logic [STATE_W-1:0] PS_MAJ_START    = 5'd8;
  localparam logic [STATE_W-1:0] PS_MAJ          = 5'd9;
  localparam logic [STATE_W-1:0] PS_MIN_START    = 5'd10;
  localparam logic [STATE_W-1:0] PS_MIN          = 5'd11;
  localparam logic [STATE_W-1:0] PS_LF1          = 5'd12;
  localparam logic [STATE_W-1:0] PS_LINE_START   = 5'd13;
  localparam logic [STATE_W-1:0] PS_LWS          = 5'd14;
  localparam logic [STATE_W-1:0] PS_NAME         = 5'd15;
  localparam logic [STATE_W-1:0] PS_SP_VALUE     = 5'd16;
  localparam logic [STATE_W-1:0] PS_VALUE        = 5'd17;
  localparam logic [STATE_W-1:0] PS_LF2          = 5'd18;
  localparam logic [STATE_W-1:0] PS_LF3          = 5'd19;

  localparam logic [1:0] STAT_PENDING = 2'd0;
  localparam logic [1:0] STAT_DONE    = 2'd1;
  localparam logic [1:0] STAT_BAD     = 2'd2;

  localparam logic [2:0] ROLE_NONE   = 3'd0;
  localparam logic [2:0] ROLE_METHOD = 3'd1;
  localparam logic [2:0] ROLE_URI    = 3'd2;
  localparam logic [2:0] ROLE_NAME   = 3'd3;
  localparam logic [2:0] ROLE_VALUE  = 3'd4;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_CTL_MAX = 8'h1F;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       restart;
  } hrhp_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] byte_role;
    logic       new_header;
    logic [7:0] out_byte;
    logic [7:0] version_major;
    logic [7:0] version_minor;
  } hrhp_out_t;

  typedef struct packed {
    logic is_ctl;
    logic is_token;
    logic is_digit;
    logic is_lws;
  } hrhp_cls_t;

endpackage

### hdl/hrhp_classify.sv
// Character class decoder for one byte of the request head.
module hrhp_classify import hrhp_pkg::*; (
  input  logic [7:0] c,
  output hrhp_cls_t  cls
);

  logic sep;

  always_comb begin
    sep = c inside {8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A, 8'h5C,
                    8'h22, 8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D};
    cls.is_ctl   = (c <= CH_CTL_MAX) || (c == CH_DEL);
    cls.is_token = (c > CH_SP) && (c < CH_DEL) && !sep;
    cls.is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    cls.is_lws   = (c == CH_SP) || (c == CH_TAB);
  end

endmodule

### hdl/hrhp_step.sv
// Next-state and result logic of the parser for one byte.
module hrhp_step import hrhp_pkg::*; #(
  parameter int VERSION_BITS = VERSION_BITS_DEF
) (
  input  logic [STATE_W-1:0]      st_r,
  input  logic                    hs_r,
  input  logic [VERSION_BITS-1:0] maj_r,
  input  logic [VERSION_BITS-1:0] min_r,
  input  hrhp_in_t                item,
  input  hrhp_cls_t               cls,
  output logic [STATE_W-1:0]      st_nxt,
  output logic                    hs_nxt,
  output logic [VERSION_BITS-1:0] maj_nxt,
  output logic [VERSION_BITS-1:0] min_nxt,
  output logic                    bad,
  output hrhp_out_t               res
);

  function automatic logic [VERSION_BITS-1:0] add_digit(
    input logic [VERSION_BITS-1:0] acc,
    input logic [3:0]              d
  );
    logic [VERSION_BITS+3:0] w;
    begin
      w = ((VERSION_BITS+4)'(acc) << 3) + ((VERSION_BITS+4)'(acc) << 1)
          + (VERSION_BITS+4)'(d);
      add_digit = (|w[VERSION_BITS+3:VERSION_BITS]) ? '1 : w[VERSION_BITS-1:0];
    end
  endfunction

  logic [7:0]              c;
  logic [3:0]              dig;
  logic [STATE_W-1:0]      st_e;
  logic                    hs_e;
  logic [VERSION_BITS-1:0] maj_e;
  logic [VERSION_BITS-1:0] min_e;
  logic [1:0]              status;
  logic [2:0]              role;
  logic                    nh;

  always_comb begin
    c      = item.in_byte;
    dig    = 4'(c - CH_ZERO);
    st_e   = item.restart ? PS_METHOD_START : st_r;
    hs_e   = item.restart ? 1'b0 : hs_r;
    maj_e  = item.restart ? '0 : maj_r;
    min_e  = item.restart ? '0 : min_r;
    st_nxt  = st_e;
    hs_nxt  = hs_e;
    maj_nxt = maj_e;
    min_nxt = min_e;
    status  = STAT_PENDING;
    role    = ROLE_NONE;
    nh      = 1'b0;
    bad     = 1'b0;
    case (st_e)
      PS_METHOD_START: begin
        if (cls.is_token) begin
          st_nxt = PS_METHOD;
          role   = ROLE_METHOD;
        end else bad = 1'b1;
      end
      PS_METHOD: begin
        if (c == CH_SP) st_nxt = PS_URI;
        else if (cls.is_token) role = ROLE_METHOD;
        else bad = 1'b1;
      end
      PS_URI: begin
        if (c == CH_SP) st_nxt = PS_H;
        else if (cls.is_ctl) bad = 1'b1;
        else role = ROLE_URI;
      end
      PS_H:  if (c == CH_H) st_nxt = PS_T1; else bad = 1'b1;
      PS_T1: if (c == CH_T) st_nxt = PS_T2; else bad = 1'b1;
      PS_T2: if (c == CH_T) st_nxt = PS_P; else bad = 1'b1;
      PS_P:  if (c == CH_P) st_nxt = PS_SLASH; else bad = 1'b1;
      PS_SLASH: begin
        if (c == CH_SLASH) begin
          maj_nxt = '0;
          min_nxt = '0;
          st_nxt  = PS_MAJ_START;
        end else bad = 1'b1;
      end
      PS_MAJ_START: begin
        if (cls.is_digit) begin
          maj_nxt = add_digit(maj_e, dig);
          st_nxt  = PS_MAJ;
        end else bad = 1'b1;
      end
      PS_MAJ: begin
        if (c == CH_DOT) st_nxt = PS_MIN_START;
        else if (cls.is_digit) maj_nxt = add_digit(maj_e, dig);
        else bad = 1'b1;
      end
      PS_MIN_START: begin
        if (cls.is_digit) begin
          min_nxt = add_digit(min_e, dig);
          st_nxt  = PS_MIN;
        end else bad = 1'b1;
      end
      PS_MIN: begin
        if (c == CH_CR) st_nxt = PS_LF1;
        else if (cls.is_digit) min_nxt = add_digit(min_e, dig);
        else bad = 1'b1;
      end
      PS_LF1: if (c == CH_LF) st_nxt = PS_LINE_START; else bad = 1'b1;
      PS_LINE_START: begin
        if (c == CH_CR) st_nxt = PS_LF3;
        else if (hs_e && cls.is_lws) st_nxt = PS_LWS;
        else if (cls.is_token) begin
          hs_nxt = 1'b1;
          st_nxt = PS_NAME;
          role   = ROLE_NAME;
          nh     = 1'b1;
        end else bad = 1'b1;
      end
      PS_LWS: begin
        if (c == CH_CR) st_nxt = PS_LF2;
        else if (cls.is_lws) st_nxt = PS_LWS;
        else if (cls.is_ctl) bad = 1'b1;
        else begin
          st_nxt = PS_VALUE;
          role   = ROLE_VALUE;
        end
      end
      PS_NAME: begin
        if (c == CH_COLON) st_nxt = PS_SP_VALUE;
        else if (cls.is_token) role = ROLE_NAME;
        else bad = 1'b1;
      end
      PS_SP_VALUE: if (c == CH_SP) st_nxt = PS_VALUE; else bad = 1'b1;
      PS_VALUE: begin
        if (c == CH_CR) st_nxt = PS_LF2;
        else if (cls.is_ctl) bad = 1'b1;
        else role = ROLE_VALUE;
      end
      PS_LF2: if (c == CH_LF) st_nxt = PS_LINE_START; else bad = 1'b1;
      PS_LF3: if (c == CH_LF) status = STAT_DONE; else bad = 1'b1;
      default: bad = 1'b1;
    endcase
    if (bad) begin
      st_nxt  = st_e;
      hs_nxt  = hs_e;
      maj_nxt = maj_e;
      min_nxt = min_e;
      status  = STAT_BAD;
      role    = ROLE_NONE;
      nh      = 1'b0;
    end
    res.status        = status;
    res.byte_role     = role;
    res.new_header    = nh;
    res.out_byte      = c;
    res.version_major = 8'(maj_nxt);
    res.version_minor = 8'(min_nxt);
  end

endmodule

### hdl/http_request_head_parser.sv
// Top level of the HTTP request head parser: input register, parse step, result register.
// A byte accepted into the input register is parsed and then held in the result register
// once that register is free; one byte item per cycle while out_ready does not stall the output.
// Reset clears both valid flags and returns the parser to method start with cleared
// version counts; no clearing pass is needed.
`include "http_request_head_parser_macros.svh"

module http_request_head_parser import hrhp_pkg::*; #(
  parameter int VERSION_BITS = VERSION_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  hrhp_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output hrhp_out_t out_data
);

  hrhp_in_t                in_r;
  logic                    s1_valid_r;
  logic                    s1_adv;
  logic                    out_valid_r;
  hrhp_out_t               out_r;
  logic [STATE_W-1:0]      state_r;
  logic                    hs_r;
  logic [VERSION_BITS-1:0] maj_r;
  logic [VERSION_BITS-1:0] min_r;
  logic [STATE_W-1:0]      state_nxt;
  logic                    hs_nxt;
  logic [VERSION_BITS-1:0] maj_nxt;
  logic [VERSION_BITS-1:0] min_nxt;
  logic                    step_bad;
  hrhp_out_t               step_res;
  hrhp_cls_t               cls;

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  hrhp_classify u_classify (
    .c   (in_r.in_byte),
    .cls (cls)
  );

  hrhp_step #(
    .VERSION_BITS (VERSION_BITS)
  ) u_step (
    .st_r    (state_r),
    .hs_r    (hs_r),
    .maj_r   (maj_r),
    .min_r   (min_r),
    .item    (in_r),
    .cls     (cls),
    .st_nxt  (state_nxt),
    .hs_nxt  (hs_nxt),
    .maj_nxt (maj_nxt),
    .min_nxt (min_nxt),
    .bad     (step_bad),
    .res     (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= PS_METHOD_START;
      hs_r        <= 1'b0;
      maj_r       <= '0;
      min_r       <= '0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
        hs_r        <= hs_nxt;
        maj_r       <= maj_nxt;
        min_r       <= min_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (s1_adv) begin
      out_r <= step_res;
    end
  end

  `HRHP_ASSERT_NEXT(a_bad_keeps_state, s1_adv && step_bad && !in_r.restart,
                    $stable(state_r) && $stable(hs_r))
  `HRHP_ASSERT_IMPL(a_done_only_from_lf3, s1_adv && step_res.status == STAT_DONE,
                    state_r == PS_LF3 && !in_r.restart)
  `HRHP_ASSERT_IMPL(a_header_seen_clears_on_restart, $fell(hs_r),
                    $past(s1_adv && in_r.restart))
  `HRHP_ASSERT_IMPL(a_new_header_is_name, out_valid_r && out_r.new_header,
                    out_r.byte_role == ROLE_NAME && out_r.status == STAT_PENDING)

endmodule
